// ===== hw/rtl/cmr_pkg.sv =====
// cmr_pkg: shared constants, status codes and the command record passed from
// the frame classifier to the byte sequencer of the multi-frame reassembler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmr_pkg;

    localparam int MAX_FRAME_DATA    = 8;
    localparam int HDR_BYTES         = 4;
    localparam int MAX_ITEMS         = HDR_BYTES + MAX_FRAME_DATA - 1;
    localparam int ITEM_IDX_W        = $clog2(MAX_ITEMS);
    localparam int CMD_FIFO_DEPTH    = 2;

    localparam int MSG_ID_W          = 7;
    localparam int IDX_W             = 11;
    localparam int DECL_W            = 15;
    localparam int RECV_W            = 16;

    localparam logic [MSG_ID_W-1:0] MSG_ID_RESET   = 7'd117;
    localparam logic [3:0]          VERSION_NIBBLE = 4'h3;
    localparam logic [DECL_W-1:0]   MIN_DECL_LEN   = 15'd3;
    localparam logic [DECL_W-1:0]   MAX_DECL_LEN   = 15'd1393;
    localparam logic [IDX_W-1:0]    DGRAM_OVERHEAD = 11'd7;
    localparam logic [IDX_W-1:0]    IDX_MAX        = 11'd2047;

    typedef enum logic [1:0] {
        ST_PROGRESS = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    typedef struct packed {
        status_t                         status;
        logic                            has_bytes;
        logic                            first;
        logic [ITEM_IDX_W-1:0]           last_idx;
        logic [IDX_W-1:0]                msg_len;
        logic [MAX_ITEMS-1:0][7:0]       bytes;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmr_front.sv =====
// cmr_front: accepts one frame a cycle while the command queue has room, checks it
// against the reception state and turns it into a command record for the byte
// sequencer. Depends on cmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmr_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [cmr_pkg::MSG_ID_W-1:0]  cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [31:0]                   frame_ident,
    input  wire logic [3:0]                    frame_len,
    input  wire logic [7:0]                    data_b0,
    input  wire logic [7:0]                    data_b1,
    input  wire logic [7:0]                    data_b2,
    input  wire logic [7:0]                    data_b3,
    input  wire logic [7:0]                    data_b4,
    input  wire logic [7:0]                    data_b5,
    input  wire logic [7:0]                    data_b6,
    input  wire logic [7:0]                    data_b7,
    input  wire logic                          cmd_full,
    output logic                               cmd_push,
    output cmr_pkg::cmd_t                      cmd
);

    logic [cmr_pkg::MSG_ID_W-1:0] msg_id_reg, msg_id_next;
    logic [7:0]                   exp_fn_reg, exp_fn_next;
    logic [cmr_pkg::DECL_W-1:0]   decl_reg, decl_next;
    logic [cmr_pkg::RECV_W-1:0]   recv_reg, recv_next;

    logic                         ignore, base_ok, is_first, first_ok, later_ok, frame_ok;
    logic                         done;
    logic [cmr_pkg::DECL_W-1:0]   dl, decl_new;
    logic [cmr_pkg::RECV_W-1:0]   resid, recv_new;
    logic [3:0]                   exp_len_first, exp_len_later;
    logic [7:0]                   d [cmr_pkg::MAX_FRAME_DATA-1];

    localparam logic [3:0] FULL_LEN = 4'(cmr_pkg::MAX_FRAME_DATA);

    assign in_ready = !cmd_full;
    assign cmd_push = in_valid && in_ready;

    always_comb begin
        d[0] = data_b1;
        d[1] = data_b2;
        d[2] = data_b3;
        d[3] = data_b4;
        d[4] = data_b5;
        d[5] = data_b6;
        d[6] = data_b7;
    end

    always_comb begin
        ignore   = (exp_fn_reg == 8'd0);
        base_ok  = (frame_ident[31:25] == msg_id_reg) && (frame_len >= 4'd2)
                   && (data_b0 == exp_fn_reg);
        is_first = (data_b0 == 8'd1);

        dl            = {data_b3[6:0], data_b2};
        exp_len_first = (dl > cmr_pkg::MIN_DECL_LEN) ? FULL_LEN : (FULL_LEN - 4'd1);
        first_ok      = (data_b1[7:4] == cmr_pkg::VERSION_NIBBLE)
                        && (dl >= cmr_pkg::MIN_DECL_LEN) && (dl <= cmr_pkg::MAX_DECL_LEN)
                        && (frame_len == exp_len_first);

        // residual bytes still owed by the datagram
        resid         = {1'b0, decl_reg} - recv_reg;
        exp_len_later = (resid >= 16'(cmr_pkg::MAX_FRAME_DATA - 1)) ? FULL_LEN
                        : (4'd1 + {1'b0, resid[2:0]});
        later_ok      = (frame_len == exp_len_later);

        frame_ok = base_ok && (is_first ? first_ok : later_ok);
        decl_new = is_first ? dl : decl_reg;
        recv_new = is_first ? ((frame_len == FULL_LEN) ? 16'd4 : 16'd3)
                            : (recv_reg + {12'd0, frame_len} - 16'd1);
        done     = (recv_new == {1'b0, decl_new});
    end

    always_comb begin
        cmd = '0;
        if (ignore) begin
            cmd.status = cmr_pkg::ST_IGNORED;
        end else if (!frame_ok) begin
            cmd.status = cmr_pkg::ST_ERROR;
        end else begin
            cmd.has_bytes = 1'b1;
            cmd.first     = is_first;
            cmd.status    = done ? cmr_pkg::ST_COMPLETE : cmr_pkg::ST_PROGRESS;
            cmd.msg_len   = done ? (cmr_pkg::DGRAM_OVERHEAD + decl_new[cmr_pkg::IDX_W-1:0])
                                 : '0;
            if (is_first) begin
                // 22-bit identifier low byte first, then a zero byte
                cmd.bytes[0] = frame_ident[10:3];
                cmd.bytes[1] = frame_ident[18:11];
                cmd.bytes[2] = {2'b00, frame_ident[24:19]};
                cmd.bytes[3] = 8'd0;
                for (int k = 0; k < cmr_pkg::MAX_FRAME_DATA - 1; k++) begin
                    cmd.bytes[cmr_pkg::HDR_BYTES + k] = d[k];
                end
                cmd.last_idx = cmr_pkg::ITEM_IDX_W'(frame_len + 4'd2);
            end else begin
                for (int k = 0; k < cmr_pkg::MAX_FRAME_DATA - 1; k++) begin
                    cmd.bytes[k] = d[k];
                end
                cmd.last_idx = cmr_pkg::ITEM_IDX_W'(frame_len - 4'd2);
            end
        end
    end

    always_comb begin
        msg_id_next = cfg_we ? cfg_wdata : msg_id_reg;
        exp_fn_next = exp_fn_reg;
        decl_next   = decl_reg;
        recv_next   = recv_reg;
        if (cmd_push && !ignore) begin
            if (!frame_ok || done) begin
                exp_fn_next = 8'd1;
                decl_next   = '0;
                recv_next   = '0;
            end else begin
                exp_fn_next = exp_fn_reg + 8'd1;
                decl_next   = decl_new;
                recv_next   = recv_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_id_reg <= cmr_pkg::MSG_ID_RESET;
            exp_fn_reg <= 8'd1;
            decl_reg   <= '0;
            recv_reg   <= '0;
        end else begin
            msg_id_reg <= msg_id_next;
            exp_fn_reg <= exp_fn_next;
            decl_reg   <= decl_next;
            recv_reg   <= recv_next;
        end
    end

    a_err_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push && !ignore && !frame_ok |=> exp_fn_reg == 8'd1 && recv_reg == '0)
        else $error("rejected frame did not restart reception");

endmodule

`default_nettype wire

// ===== hw/rtl/cmr_fifo.sv =====
// cmr_fifo: small register queue of command records between the classifier
// and the byte sequencer. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module cmr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == FULL_CNT);
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== hw/rtl/cmr_back.sv =====
// cmr_back: byte sequencer; takes command records from the queue and plays
// them out as result items, one a cycle unless the output stalls, through an
// output register. Depends on cmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmr_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    input  wire cmr_pkg::cmd_t               cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic [cmr_pkg::IDX_W-1:0]        byte_index,
    output cmr_pkg::status_t                 frame_status,
    output logic [cmr_pkg::IDX_W-1:0]        message_length,
    output logic                             last_of_run
);

    cmr_pkg::cmd_t                   cur_reg, cur_next;
    logic                            active_reg, active_next;
    logic [cmr_pkg::ITEM_IDX_W-1:0]  cnt_reg, cnt_next;
    logic [cmr_pkg::IDX_W-1:0]       wp_reg, wp_next;

    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      byte_reg, byte_next;
    logic                            bvalid_reg, bvalid_next;
    logic [cmr_pkg::IDX_W-1:0]       index_reg, index_next;
    cmr_pkg::status_t                status_reg, status_next;
    logic [cmr_pkg::IDX_W-1:0]       mlen_reg, mlen_next;
    logic                            last_reg, last_next;

    logic out_free, item_last, emit, load;

    assign out_free  = !m_valid_reg || out_ready;
    assign item_last = !cur_reg.has_bytes || (cnt_reg == cur_reg.last_idx);
    assign emit      = out_free && active_reg;
    // fetch the next record while the final item of this one goes out
    assign load      = out_free && (!active_reg || item_last) && cmd_valid;
    assign cmd_pop   = load;

    always_comb begin
        cur_next     = cur_reg;
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        wp_next      = wp_reg;
        m_valid_next = m_valid_reg;
        byte_next    = byte_reg;
        bvalid_next  = bvalid_reg;
        index_next   = index_reg;
        status_next  = status_reg;
        mlen_next    = mlen_reg;
        last_next    = last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            bvalid_next  = cur_reg.has_bytes;
            byte_next    = cur_reg.has_bytes ? cur_reg.bytes[cnt_reg] : 8'd0;
            index_next   = cur_reg.has_bytes ? wp_reg : '0;
            status_next  = item_last ? cur_reg.status : cmr_pkg::ST_PROGRESS;
            mlen_next    = item_last ? cur_reg.msg_len : '0;
            last_next    = item_last;
            cnt_next     = cnt_reg + cmr_pkg::ITEM_IDX_W'(1);
            if (cur_reg.has_bytes && (wp_reg != cmr_pkg::IDX_MAX)) begin
                wp_next = wp_reg + cmr_pkg::IDX_W'(1);
            end
            if (item_last) begin
                active_next = 1'b0;
            end
        end else if (out_free) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            cur_next    = cmd;
            active_next = 1'b1;
            cnt_next    = '0;
            if (cmd.has_bytes && cmd.first) begin
                wp_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cnt_reg     <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            cnt_reg     <= cnt_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        index_reg  <= index_next;
        status_reg <= status_next;
        mlen_reg   <= mlen_next;
        last_reg   <= last_next;
    end

    assign out_valid      = m_valid_reg;
    assign out_byte       = byte_reg;
    assign byte_valid     = bvalid_reg;
    assign byte_index     = index_reg;
    assign frame_status   = status_reg;
    assign message_length = mlen_reg;
    assign last_of_run    = last_reg;

    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && bvalid_reg |->
            status_reg != cmr_pkg::ST_ERROR && status_reg != cmr_pkg::ST_IGNORED)
        else $error("data byte carries error or ignored status");

    a_mid_item_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !last_reg |-> status_reg == cmr_pkg::ST_PROGRESS && mlen_reg == '0)
        else $error("non-final item carries status or length");

endmodule

`default_nettype wire

// ===== hw/rtl/can_multiframe_reassembler_core.sv =====
// can_multiframe_reassembler_core: top level; frame classifier, command queue
// and byte sequencer. Depends on cmr_pkg, cmr_front, cmr_fifo, cmr_back.
// A frame's first result item goes through the command queue, the current record
// register and the output register. Throughput: one result item per cycle while
// m_tready allows; a frame gives 1 to 11 result items. Frames are accepted one per
// cycle while the command queue has room.
// Reset: aresetn synchronous active low; expects frame 1, message id 117, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module can_multiframe_reassembler_core #(
    parameter int FIFO_DEPTH = cmr_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [cmr_pkg::MSG_ID_W-1:0] cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // frame_ident[31:0] frame_len[35:32] data_b0[43:36] .. data_b7[99:92], zero pad
    input  wire logic [103:0]                 s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // out_byte[7:0] byte_index[18:8] message_length[29:19], zero pad
    output logic [31:0]                       m_tdata,
    // byte_valid[0] frame_status[2:1]
    output logic [2:0]                        m_tuser,
    output logic                              m_tlast
);

    cmr_pkg::cmd_t     push_cmd, pop_cmd;
    logic              cmd_push, cmd_pop, cmd_full, cmd_valid;
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic [10:0]       byte_index, message_length;
    cmr_pkg::status_t  frame_status;

    cmr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .frame_ident (s_tdata[31:0]),
        .frame_len   (s_tdata[35:32]),
        .data_b0     (s_tdata[43:36]),
        .data_b1     (s_tdata[51:44]),
        .data_b2     (s_tdata[59:52]),
        .data_b3     (s_tdata[67:60]),
        .data_b4     (s_tdata[75:68]),
        .data_b5     (s_tdata[83:76]),
        .data_b6     (s_tdata[91:84]),
        .data_b7     (s_tdata[99:92]),
        .cmd_full    (cmd_full),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    cmr_fifo #(
        .WIDTH ($bits(cmr_pkg::cmd_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .din     (push_cmd),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .valid   (cmd_valid),
        .dout    (pop_cmd)
    );

    cmr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd            (pop_cmd),
        .cmd_pop        (cmd_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .byte_index     (byte_index),
        .frame_status   (frame_status),
        .message_length (message_length),
        .last_of_run    (m_tlast)
    );

    assign m_tdata = {2'b00, message_length, byte_index, out_byte};
    assign m_tuser = {frame_status, byte_valid};

endmodule

`default_nettype wire
